// ===== rtl/core/nnzs_pkg.sv =====
package nnzs_pkg;

  localparam int unsigned SourceWidth  = 224;
  localparam int unsigned SourceHeight = 144;
  localparam int unsigned SourceStride = 224;
  localparam int unsigned PanelWidth   = 240;
  localparam int unsigned PanelHeight  = 135;
  localparam int unsigned MinWindow    = 16;
  localparam int unsigned ZoomUnity    = 100;

  // Fit-mode geometry is fixed at elaboration.
  localparam bit WidthLimited =
      (PanelWidth * SourceHeight) <= (PanelHeight * SourceWidth);
  localparam int unsigned FitAreaWRaw =
      WidthLimited ? PanelWidth : (SourceWidth * PanelHeight) / SourceHeight;
  localparam int unsigned FitAreaHRaw =
      WidthLimited ? (SourceHeight * PanelWidth) / SourceWidth : PanelHeight;
  localparam int unsigned FitAreaW = (FitAreaWRaw < 1) ? 1 : FitAreaWRaw;
  localparam int unsigned FitAreaH = (FitAreaHRaw < 1) ? 1 : FitAreaHRaw;
  localparam int unsigned FitOffX  = (PanelWidth - FitAreaW) / 2;
  localparam int unsigned FitOffY  = (PanelHeight - FitAreaH) / 2;

  // Reciprocals for dividing a 16-bit product by the active area size.
  localparam int unsigned RecipShift = 16;
  localparam int unsigned RecipFullW = (1 << RecipShift) / PanelWidth;
  localparam int unsigned RecipFullH = (1 << RecipShift) / PanelHeight;
  localparam int unsigned RecipFitW  = (1 << RecipShift) / FitAreaW;
  localparam int unsigned RecipFitH  = (1 << RecipShift) / FitAreaH;

  // Window-size divider widths.
  localparam int unsigned DivNumW = 18;
  localparam int unsigned DivDenW = 10;
  localparam int unsigned DivTagW = 8;

  localparam logic [31:0] AddrFullscreen = 32'd0;
  localparam logic [31:0] AddrZoom       = 32'd4;

  typedef enum logic [1:0] {
    REG_FULLSCREEN = 2'b01,
    REG_ZOOM       = 2'b10
  } reg_sel_t;

endpackage

// ===== rtl/core/nnzs_divider.sv =====
// Restoring divider, one quotient bit per stage, fully pipelined.
module nnzs_divider
  import nnzs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [DivNumW-1:0] num,
  input  logic [DivDenW-1:0] den,
  input  logic [DivTagW-1:0] in_tag,
  output logic               out_valid,
  output logic [DivNumW-1:0] quot,
  output logic [DivTagW-1:0] out_tag
);

  logic [DivNumW:0]    vld;
  logic [DivNumW-1:0]  q   [DivNumW+1];
  logic [DivDenW:0]    rem [DivNumW+1];
  logic [DivDenW-1:0]  dv  [DivNumW+1];
  logic [DivTagW-1:0]  tg  [DivNumW+1];

  assign vld[0] = in_valid;
  assign q[0]   = num;
  assign rem[0] = '0;
  assign dv[0]  = den;
  assign tg[0]  = in_tag;

  for (genvar s = 0; s < DivNumW; s++) begin : g_stage
    logic [DivDenW+1:0] shifted;
    logic [DivDenW+1:0] diff;
    assign shifted = {rem[s], q[s][DivNumW-1]};
    assign diff    = shifted - {2'b00, dv[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      dv[s+1] <= dv[s];
      tg[s+1] <= tg[s];
      if (!diff[DivDenW+1]) begin
        rem[s+1] <= diff[DivDenW:0];
        q[s+1]   <= {q[s][DivNumW-2:0], 1'b1};
      end else begin
        rem[s+1] <= shifted[DivDenW:0];
        q[s+1]   <= {q[s][DivNumW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[DivNumW];
  assign quot      = q[DivNumW];
  assign out_tag   = tg[DivNumW];

endmodule

// ===== rtl/core/nearest_neighbor_zoom_scaler.sv =====
// Throughput is one item per cycle.
// busy stays low, so start may be high in every cycle.
// The depth is set by the 18-stage pipelined divider for the zoom window, one stage
// for the offset products, two for the reciprocal division by the area size and one
// for the sums and address. Synchronous active-high reset clears the pipeline valid
// bits and sets fullscreen_mode to 1 and zoom_percent to 100.
module nearest_neighbor_zoom_scaler
  import nnzs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  dest_x,
  input  logic [7:0]  dest_y,
  output logic        done,
  output logic [7:0]  source_x,
  output logic [7:0]  source_y,
  output logic [14:0] frame_address,
  output logic [7:0]  panel_x,
  output logic [7:0]  panel_y,
  output logic        in_area,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       fullscreen_mode;
  logic [9:0] zoom_percent;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fullscreen_mode <= 1'b1;
      zoom_percent    <= 10'(ZoomUnity);
    end else if (psel && penable && pwrite) begin
      if ({29'd0, paddr} == AddrFullscreen) fullscreen_mode <= pwdata[0];
      if ({29'd0, paddr} == AddrZoom)       zoom_percent    <= pwdata[9:0];
    end
  end

  always_comb begin
    prdata = '0;
    if ({29'd0, paddr} == AddrFullscreen) prdata = {31'd0, fullscreen_mode};
    if ({29'd0, paddr} == AddrZoom)       prdata = {22'd0, zoom_percent};
  end

  // Window sizes are derived from registers only, in the same pipeline; the user
  // must write config only while idle, which the block does not enforce.
  logic [9:0] zoom_eff;
  assign zoom_eff = (zoom_percent == '0) ? 10'(ZoomUnity) : zoom_percent;

  // Stage A: per-item inputs, fed into dividers for window size.
  logic [17:0] win_w_raw, win_h_raw;
  logic        dw_v, dh_v;
  logic [7:0]  dw_tag, dh_tag;

  nnzs_divider u_div_ww (
    .clk, .rst, .in_valid(start), .num(18'(SourceWidth * ZoomUnity)),
    .den(zoom_eff), .in_tag(dest_x),
    .out_valid(dw_v), .quot(win_w_raw), .out_tag(dw_tag)
  );
  nnzs_divider u_div_wh (
    .clk, .rst, .in_valid(start), .num(18'(SourceHeight * ZoomUnity)),
    .den(zoom_eff), .in_tag(dest_y),
    .out_valid(dh_v), .quot(win_h_raw), .out_tag(dh_tag)
  );

  // Clamp and multiply by destination.
  logic [7:0]  win_w, win_h;
  logic [15:0] prod_x, prod_y;
  logic [8:0]  area_w, area_h;
  logic        m_v;
  logic [7:0]  m_dx, m_dy, m_w, m_h;

  always_comb begin
    if (win_w_raw < 18'(MinWindow))        win_w = 8'(MinWindow);
    else if (win_w_raw > 18'(SourceWidth)) win_w = 8'(SourceWidth);
    else                                   win_w = win_w_raw[7:0];
    if (win_h_raw < 18'(MinWindow))         win_h = 8'(MinWindow);
    else if (win_h_raw > 18'(SourceHeight)) win_h = 8'(SourceHeight);
    else                                    win_h = win_h_raw[7:0];
  end

  assign area_w = fullscreen_mode ? 9'(PanelWidth)  : 9'(FitAreaW);
  assign area_h = fullscreen_mode ? 9'(PanelHeight) : 9'(FitAreaH);

  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else     m_v <= dw_v & dh_v;
    prod_x <= 16'(dw_tag) * 16'(win_w);
    prod_y <= 16'(dh_tag) * 16'(win_h);
    m_dx   <= dw_tag;
    m_dy   <= dh_tag;
    m_w    <= win_w;
    m_h    <= win_h;
  end

  // Division by the area size through its reciprocal. The estimate is low by
  // at most one, so a single compare and subtract in the next stage fixes it.
  logic [16:0] recip_x, recip_y;
  logic [32:0] est_x, est_y;
  logic        r_v;
  logic [15:0] r_px, r_py;
  logic [8:0]  r_qx, r_qy;
  logic [7:0]  r_dx, r_w, r_dy, r_h;

  assign recip_x = fullscreen_mode ? 17'(RecipFullW) : 17'(RecipFitW);
  assign recip_y = fullscreen_mode ? 17'(RecipFullH) : 17'(RecipFitH);
  assign est_x   = 33'(prod_x) * 33'(recip_x);
  assign est_y   = 33'(prod_y) * 33'(recip_y);

  always_ff @(posedge clk) begin
    if (rst) r_v <= 1'b0;
    else     r_v <= m_v;
    r_qx <= 9'(est_x >> RecipShift);
    r_qy <= 9'(est_y >> RecipShift);
    r_px <= prod_x;
    r_py <= prod_y;
    r_dx <= m_dx;
    r_w  <= m_w;
    r_dy <= m_dy;
    r_h  <= m_h;
  end

  logic [17:0] back_x, back_y;
  logic        q_v;
  logic [8:0]  sx_q, sy_q;
  logic [7:0]  f_dx, f_w, f_dy, f_h;

  assign back_x = 18'(r_qx) * 18'(area_w);
  assign back_y = 18'(r_qy) * 18'(area_h);

  always_ff @(posedge clk) begin
    if (rst) q_v <= 1'b0;
    else     q_v <= r_v;
    sx_q <= ((18'(r_px) - back_x) >= 18'(area_w)) ? r_qx + 9'd1 : r_qx;
    sy_q <= ((18'(r_py) - back_y) >= 18'(area_h)) ? r_qy + 9'd1 : r_qy;
    f_dx <= r_dx;
    f_w  <= r_w;
    f_dy <= r_dy;
    f_h  <= r_h;
  end

  // Final stage: origin sums, address, area check.
  logic [8:0] sx, sy;
  logic       in_range;
  logic [8:0] off_x, off_y;
  assign sx = 9'((SourceWidth - {1'b0, f_w}) >> 1) + sx_q;
  assign sy = 9'((SourceHeight - {1'b0, f_h}) >> 1) + sy_q;
  assign in_range = ({1'b0, f_dx} < area_w) && ({1'b0, f_dy} < area_h);
  assign off_x = fullscreen_mode ? 9'd0 : 9'(FitOffX);
  assign off_y = fullscreen_mode ? 9'd0 : 9'(FitOffY);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= q_v;
    in_area       <= in_range;
    source_x      <= in_range ? sx[7:0] : '0;
    source_y      <= in_range ? sy[7:0] : '0;
    frame_address <= in_range ? 15'(18'(sy) * 18'(SourceStride) + 18'(sx)) : '0;
    panel_x       <= in_range ? 8'(off_x + 9'(f_dx)) : '0;
    panel_y       <= in_range ? 8'(off_y + 9'(f_dy)) : '0;
  end

endmodule
